### design/urbs_pkg.sv
`timescale 1ns / 1ps
package urbs_pkg;

    // default ring depths
    localparam int TX_DEPTH_DEF = 1024;
    localparam int RX_DEPTH_DEF = 256;

    // field widths
    localparam int ACTION_W    = 3;
    localparam int BYTE_W      = 8;
    localparam int CAUSE_W     = 2;
    localparam int STATUS_W    = 3;
    localparam int SEL_W       = 2;
    localparam int TX_SIZE_W   = 11;
    localparam int RX_SIZE_W   = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    // register reset values
    localparam logic [TX_SIZE_W-1:0] TX_SIZE_RST = 11'd1024;
    localparam logic [RX_SIZE_W-1:0] RX_SIZE_RST = 9'd256;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT      = 3'd0,
        ACT_GET      = 3'd1,
        ACT_IRQ      = 3'd2,
        ACT_FLUSH_TX = 3'd3,
        ACT_FLUSH_RX = 3'd4
    } t_action;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_MODEM   = 2'd0,
        CAUSE_TX_ROOM = 2'd1,
        CAUSE_RX_DATA = 2'd2,
        CAUSE_LINE    = 2'd3
    } t_cause;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_TX_FULL     = 3'd1,
        ST_RX_EMPTY    = 3'd2,
        ST_RX_OVERFLOW = 3'd3,
        ST_NO_CAUSE    = 3'd4
    } t_status;

    typedef enum logic [SEL_W-1:0] {
        FRST_NONE = 2'd0,
        FRST_TX   = 2'd1,
        FRST_RX   = 2'd2
    } t_fifo_rst;

    typedef enum logic [SEL_W-1:0] {
        SIDE_NONE  = 2'd0,
        SIDE_MODEM = 2'd1,
        SIDE_LINE  = 2'd2
    } t_side;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TX_SIZE     = 2'd0,
        CFG_RX_SIZE     = 2'd1,
        CFG_FIFO_IN_USE = 2'd2
    } t_cfg_reg;

    // per-request command to one ring
    typedef struct packed {
        logic flush;
        logic push;
        logic pop;
        logic rd_en;
    } t_ring_cmd;

endpackage

### design/urbs_if.sv
`timescale 1ns / 1ps
interface urbs_in_if
    import urbs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   data_byte;
    logic                irq_pending;
    logic [CAUSE_W-1:0]  irq_cause;
    logic                tx_room;

    modport source (output valid, action, data_byte, irq_pending, irq_cause, tx_room,
                    input ready);
    modport sink   (input valid, action, data_byte, irq_pending, irq_cause, tx_room,
                    output ready);
endinterface

interface urbs_out_if
    import urbs_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [BYTE_W-1:0]    read_byte;
    logic                 uart_write_valid;
    logic [BYTE_W-1:0]    uart_write_byte;
    logic                 tx_irq_enable;
    logic [SEL_W-1:0]     fifo_reset;
    logic [SEL_W-1:0]     side_read;
    logic [TX_SIZE_W-1:0] tx_level;
    logic [RX_SIZE_W-1:0] rx_level;

    modport source (output valid, status, read_byte, uart_write_valid, uart_write_byte,
                    tx_irq_enable, fifo_reset, side_read, tx_level, rx_level,
                    input ready);
    modport sink   (input valid, status, read_byte, uart_write_valid, uart_write_byte,
                    tx_irq_enable, fifo_reset, side_read, tx_level, rx_level,
                    output ready);
endinterface

interface urbs_cfg_if
    import urbs_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink   (input valid, index, wdata, output ready);
endinterface

### design/urbs_ring.sv
`timescale 1ns / 1ps
module urbs_ring
    import urbs_pkg::*;
#(
    parameter int DEPTH  = TX_DEPTH_DEF,
    parameter int SIZE_W = TX_SIZE_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_ring_cmd                     i_cmd,
    input  logic [BYTE_W-1:0]             i_wdata,
    input  logic [SIZE_W-1:0]             i_size,
    output logic [$clog2(DEPTH+1)-1:0]    o_count,
    output logic                          o_full,
    output logic                          o_empty,
    output logic [BYTE_W-1:0]             o_rdata
);

    localparam int PW  = $clog2(DEPTH);
    localparam int SZW = $clog2(DEPTH + 1);
    localparam int CW  = (SIZE_W > SZW) ? SIZE_W : SZW;
    localparam logic [CW-1:0] DEPTH_X = CW'(DEPTH);

    logic [BYTE_W-1:0] mem [DEPTH];

    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [SZW-1:0] r_count;
    logic [CW-1:0]  size_x;
    logic [PW:0]    eff_size;
    logic [PW:0]    wr_inc, rd_inc;
    logic [PW-1:0]  n_wr_ptr, n_rd_ptr;

    // size of zero acts as one, oversize acts as the depth
    always_comb begin
        size_x = CW'(i_size);
        if (size_x == '0) begin
            eff_size = (PW+1)'(1);
        end else if (size_x > DEPTH_X) begin
            eff_size = (PW+1)'(DEPTH);
        end else begin
            eff_size = (PW+1)'(size_x);
        end
        wr_inc   = (PW+1)'(r_wr_ptr) + (PW+1)'(1);
        rd_inc   = (PW+1)'(r_rd_ptr) + (PW+1)'(1);
        n_wr_ptr = (wr_inc >= eff_size) ? '0 : wr_inc[PW-1:0];
        n_rd_ptr = (rd_inc >= eff_size) ? '0 : rd_inc[PW-1:0];
    end

    assign o_count = r_count;
    assign o_full  = ((PW+1)'(r_count) >= eff_size);
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else if (i_cmd.flush) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else if (i_cmd.push) begin
            r_wr_ptr <= n_wr_ptr;
            r_count  <= r_count + SZW'(1);
        end else if (i_cmd.pop) begin
            r_rd_ptr <= n_rd_ptr;
            r_count  <= r_count - SZW'(1);
        end
    end

    // storage, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            o_rdata <= mem[r_rd_ptr];
        end
    end

endmodule

### design/uart_ring_buffer_service.sv
`timescale 1ns / 1ps
// result: a request is answered in the cycle after it is accepted (result register)
// throughput: one request per cycle while results are taken; the rings each get at
// most one write or one registered read per request, which sets that figure
// reset: synchronous active-low; pointers, counts, interrupt enable and result valid
// clear, sizes return to the default depths, ring contents stay undefined until written
module uart_ring_buffer_service
    import urbs_pkg::*;
#(
    parameter int TX_DEPTH = TX_DEPTH_DEF,
    parameter int RX_DEPTH = RX_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    urbs_in_if.sink   i_in,
    urbs_cfg_if.sink  i_cfg,
    urbs_out_if.source o_out
);

    localparam int TX_CW = $clog2(TX_DEPTH + 1);
    localparam int RX_CW = $clog2(RX_DEPTH + 1);

    // configuration registers
    logic [TX_SIZE_W-1:0] r_tx_size;
    logic [RX_SIZE_W-1:0] r_rx_size;
    logic                 r_fifo_in_use;

    // result register (bytes come straight from the ring read registers)
    logic      r_out_valid;
    t_status   r_status,  n_status;
    t_fifo_rst r_fifo,    n_fifo;
    t_side     r_side,    n_side;
    logic      r_wvalid,  n_wvalid;
    logic      r_rvalid,  n_rvalid;
    logic      r_tx_irq,  n_tx_irq;

    t_ring_cmd tx_cmd, rx_cmd;

    logic [TX_CW-1:0]  tx_count;
    logic [RX_CW-1:0]  rx_count;
    logic              tx_full, tx_empty, rx_full, rx_empty;
    logic [BYTE_W-1:0] tx_rdata, rx_rdata;

    logic in_acc, out_acc;

    // a new request may enter as the previous result leaves
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_acc    = o_out.valid && o_out.ready;

    // configuration port, always ready; writes beyond the list are ignored
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_size     <= TX_SIZE_RST;
            r_rx_size     <= RX_SIZE_RST;
            r_fifo_in_use <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_TX_SIZE:     r_tx_size     <= i_cfg.wdata[TX_SIZE_W-1:0];
                CFG_RX_SIZE:     r_rx_size     <= i_cfg.wdata[RX_SIZE_W-1:0];
                CFG_FIFO_IN_USE: r_fifo_in_use <= i_cfg.wdata[0];
                default: ;
            endcase
        end
    end

    // decode of one request into ring commands and result fields
    always_comb begin
        tx_cmd   = '0;
        rx_cmd   = '0;
        n_status = ST_OK;
        n_fifo   = FRST_NONE;
        n_side   = SIDE_NONE;
        n_wvalid = 1'b0;
        n_rvalid = 1'b0;
        n_tx_irq = r_tx_irq;
        if (in_acc) begin
            unique case (t_action'(i_in.action))
                ACT_PUT: begin
                    if (tx_full) begin
                        n_status = ST_TX_FULL;
                    end else begin
                        tx_cmd.push = 1'b1;
                        n_tx_irq    = 1'b1;
                    end
                end
                ACT_GET: begin
                    if (rx_empty) begin
                        n_status = ST_RX_EMPTY;
                    end else begin
                        rx_cmd.rd_en = 1'b1;
                        rx_cmd.pop   = 1'b1;
                        n_rvalid     = 1'b1;
                    end
                end
                ACT_IRQ: begin
                    if (!i_in.irq_pending) begin
                        n_status = ST_NO_CAUSE;
                    end else begin
                        unique case (t_cause'(i_in.irq_cause))
                            CAUSE_MODEM: n_side = SIDE_MODEM;
                            CAUSE_TX_ROOM: begin
                                // served whether or not the enable is set
                                if (tx_empty) begin
                                    n_tx_irq = 1'b0;
                                end else if (i_in.tx_room) begin
                                    tx_cmd.rd_en = 1'b1;
                                    tx_cmd.pop   = 1'b1;
                                    n_wvalid     = 1'b1;
                                end
                            end
                            CAUSE_RX_DATA: begin
                                if (rx_full) begin
                                    n_status = ST_RX_OVERFLOW;
                                end else begin
                                    rx_cmd.push = 1'b1;
                                end
                            end
                            CAUSE_LINE: n_side = SIDE_LINE;
                            default: ;
                        endcase
                    end
                end
                ACT_FLUSH_TX: begin
                    tx_cmd.flush = 1'b1;
                    if (r_fifo_in_use) begin
                        n_fifo = FRST_TX;
                    end
                end
                ACT_FLUSH_RX: begin
                    rx_cmd.flush = 1'b1;
                    if (r_fifo_in_use) begin
                        n_fifo = FRST_RX;
                    end
                end
                default: ;   // unused action codes: ok, nothing changes
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_tx_irq    <= 1'b0;
        end else begin
            r_tx_irq <= n_tx_irq;
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status <= n_status;
            r_fifo   <= n_fifo;
            r_side   <= n_side;
            r_wvalid <= n_wvalid;
            r_rvalid <= n_rvalid;
        end
    end

    // the rings; a write lands in the ring before the next request can read it,
    // so no bypass is needed between requests
    urbs_ring #(
        .DEPTH  (TX_DEPTH),
        .SIZE_W (TX_SIZE_W)
    ) u_tx_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tx_cmd),
        .i_wdata (i_in.data_byte),
        .i_size  (r_tx_size),
        .o_count (tx_count),
        .o_full  (tx_full),
        .o_empty (tx_empty),
        .o_rdata (tx_rdata)
    );

    urbs_ring #(
        .DEPTH  (RX_DEPTH),
        .SIZE_W (RX_SIZE_W)
    ) u_rx_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (rx_cmd),
        .i_wdata (i_in.data_byte),
        .i_size  (r_rx_size),
        .o_count (rx_count),
        .o_full  (rx_full),
        .o_empty (rx_empty),
        .o_rdata (rx_rdata)
    );

    // result; levels and enable only move on an accepted request, so they hold
    // steady while the result waits
    assign o_out.valid            = r_out_valid;
    assign o_out.status           = r_status;
    assign o_out.read_byte        = r_rvalid ? rx_rdata : '0;
    assign o_out.uart_write_valid = r_wvalid;
    assign o_out.uart_write_byte  = r_wvalid ? tx_rdata : '0;
    assign o_out.tx_irq_enable    = r_tx_irq;
    assign o_out.fifo_reset       = r_fifo;
    assign o_out.side_read        = r_side;
    assign o_out.tx_level         = TX_SIZE_W'(tx_count);
    assign o_out.rx_level         = RX_SIZE_W'(rx_count);

endmodule
